@@ rtl/key_click_classifier_core_defines.svh @@
// Assertion helpers shared by the key qualifier RTL.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef KEY_CLICK_CLASSIFIER_CORE_DEFINES_SVH
`define KEY_CLICK_CLASSIFIER_CORE_DEFINES_SVH

// Checked only while out of reset
`define KCC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kcc: check failed");

// Checked at every edge, reset included
`define KCC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("kcc: check failed");

`endif

@@ rtl/kcc_pkg.sv @@
`timescale 1ns / 1ps
package kcc_pkg;

    localparam int DEF_NUM_KEYS = 4;
    localparam int CNT_W        = 16;
    localparam int LEVEL_W      = 4;
    localparam int KEY_ID_W     = 2;
    localparam int KEY_SPAN     = 1 << KEY_ID_W;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [CNT_W-1:0] DEF_DEBOUNCE = 16'd3;
    localparam logic [CNT_W-1:0] DEF_LONG     = 16'd150;
    localparam logic [CNT_W-1:0] DEF_WINDOW   = 16'd50;
    localparam logic             DEF_ACTIVE   = 1'b0;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_WINDOW   = 2'd2,
        REG_ACTIVE   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] deb_thr;
        logic [CNT_W-1:0] long_thr;
        logic [CNT_W-1:0] win_thr;
        logic             active_level;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic pressed;
        logic clear;
    } t_lane_ctl;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

endpackage

@@ rtl/kcc_if.sv @@
`timescale 1ns / 1ps
interface kcc_in_if
    import kcc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [LEVEL_W-1:0]  key_levels;
    logic [KEY_ID_W-1:0] key_id;

    modport source (output valid, cmd, key_levels, key_id, input ready);
    modport sink   (input valid, cmd, key_levels, key_id, output ready);
endinterface

interface kcc_out_if
    import kcc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] event_code;

    modport source (output valid, event_code, input ready);
    modport sink   (input valid, event_code, output ready);
endinterface

@@ rtl/kcc_lane.sv @@
`timescale 1ns / 1ps
`include "key_click_classifier_core_defines.svh"
module kcc_lane
    import kcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_lane_ctl i_ctl,
    output t_event    o_pend
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DEB1  = 3'd1,
        PH_HELD  = 3'd2,
        PH_LONG  = 3'd3,
        PH_WAIT  = 3'd4,
        PH_DEB2  = 3'd5,
        PH_HELD2 = 3'd6
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_deb, n_deb;
    logic [CNT_W-1:0] r_hold, n_hold;
    logic [CNT_W-1:0] r_win, n_win;
    t_event           r_pend, n_pend;

    logic [CNT_W-1:0] deb_inc, hold_inc, win_inc;

    assign deb_inc  = bump(r_deb);
    assign hold_inc = bump(r_hold);
    assign win_inc  = bump(r_win);

    always_comb begin
        n_phase = r_phase;
        n_deb   = r_deb;
        n_hold  = r_hold;
        n_win   = r_win;
        n_pend  = r_pend;
        if (i_ctl.clear) begin
            n_pend = EV_NONE;
        end else if (i_ctl.tick) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_ctl.pressed) begin
                        n_deb   = CNT_W'(1);
                        n_phase = PH_DEB1;
                    end
                end
                PH_DEB1: begin
                    if (i_ctl.pressed) begin
                        n_deb = deb_inc;
                        if (deb_inc >= i_cfg.deb_thr) begin
                            n_hold  = '0;
                            n_phase = PH_HELD;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_HELD: begin
                    if (!i_ctl.pressed) begin
                        n_win   = '0;
                        n_phase = PH_WAIT;
                    end else begin
                        n_hold = hold_inc;
                        if (hold_inc >= i_cfg.long_thr) begin
                            n_pend  = EV_LONG;
                            n_phase = PH_LONG;
                        end
                    end
                end
                PH_LONG, PH_HELD2: begin
                    if (!i_ctl.pressed) n_phase = PH_IDLE;
                end
                PH_WAIT: begin
                    if (i_ctl.pressed) begin
                        n_deb   = CNT_W'(1);
                        n_phase = PH_DEB2;
                    end else begin
                        n_win = win_inc;
                        if (win_inc >= i_cfg.win_thr) begin
                            n_pend  = EV_SHORT;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_DEB2: begin
                    if (i_ctl.pressed) begin
                        n_deb = deb_inc;
                        if (deb_inc >= i_cfg.deb_thr) begin
                            n_pend  = EV_DOUBLE;
                            n_phase = PH_HELD2;
                        end
                    end else begin
                        n_pend  = EV_SHORT;
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_deb   <= '0;
            r_hold  <= '0;
            r_win   <= '0;
            r_pend  <= EV_NONE;
        end else begin
            r_phase <= n_phase;
            r_deb   <= n_deb;
            r_hold  <= n_hold;
            r_win   <= n_win;
            r_pend  <= n_pend;
        end
    end

    assign o_pend = r_pend;

    // a double click can only be confirmed out of the second debounce
    `KCC_ASSERT(a_double_from_deb2,
        (r_pend == EV_DOUBLE && $past(r_pend) != EV_DOUBLE) |-> ($past(r_phase) == PH_DEB2))
    `KCC_ASSERT(a_clear_empties, i_ctl.clear |=> (r_pend == EV_NONE))

endmodule

@@ rtl/kcc_merge.sv @@
`timescale 1ns / 1ps
`include "key_click_classifier_core_defines.svh"
module kcc_merge
    import kcc_pkg::*;
#(
    parameter int NUM_KEYS = DEF_NUM_KEYS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [KEY_ID_W-1:0] i_key_id,
    input  t_event              i_pend [NUM_KEYS],
    output logic                o_ready,
    kcc_out_if.source           o_out
);

    logic [1:0] r_cnt, n_cnt;
    t_event     r_q0, n_q0;
    t_event     r_q1, n_q1;
    t_event     sel_code;
    logic       pop;

    // keys beyond the key count answer none
    always_comb begin
        sel_code = EV_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (k < KEY_SPAN && i_key_id == KEY_ID_W'(k)) sel_code = i_pend[k];
        end
    end

    assign pop = (r_cnt != 2'd0) && o_out.ready;

    // two-word queue: head drives the output, second slot soaks up a stall
    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        unique case ({i_push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) n_q0 = sel_code;
                else n_q1 = sel_code;
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_q0  = r_q1;
                n_cnt = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_q0 = sel_code;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = sel_code;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_ready          = (r_cnt != 2'd2);
    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.event_code = r_q0;

    `KCC_ASSERT_ALWAYS(a_cnt_bound, !i_rst_n || r_cnt != 2'd3)
    `KCC_ASSERT(a_push_empty,
        (r_cnt == 2'd0 && i_push) |=> (r_cnt == 2'd1 && r_q0 == $past(sel_code)))

endmodule

@@ rtl/key_click_classifier_core.sv @@
`timescale 1ns / 1ps
// A read word that is accepted has its event word registered into the output queue.
// Throughput: one word per cycle while ready is high; each key has its own lane, so a tick updates all at once.
// Ready drops only while two event words wait at the output queue.
// Reset (synchronous, active low): all keys idle, counts zero, no events pending,
// registers back to 3 / 150 / 50 / active low.
`include "key_click_classifier_core_defines.svh"
module key_click_classifier_core
    import kcc_pkg::*;
#(
    parameter int NUM_KEYS = DEF_NUM_KEYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kcc_in_if.sink             i_in,
    kcc_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg       r_cfg;
    t_reg_idx   reg_sel;
    logic       cfg_wr;
    logic       in_acc;
    logic       tick_acc;
    logic       rd_acc;
    t_event     pend [NUM_KEYS];

    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deb_thr      <= DEF_DEBOUNCE;
            r_cfg.long_thr     <= DEF_LONG;
            r_cfg.win_thr      <= DEF_WINDOW;
            r_cfg.active_level <= DEF_ACTIVE;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_DEBOUNCE: r_cfg.deb_thr      <= pwdata[CNT_W-1:0];
                REG_LONG:     r_cfg.long_thr     <= pwdata[CNT_W-1:0];
                REG_WINDOW:   r_cfg.win_thr      <= pwdata[CNT_W-1:0];
                REG_ACTIVE:   r_cfg.active_level <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_DEBOUNCE: prdata = PDATA_W'(r_cfg.deb_thr);
            REG_LONG:     prdata = PDATA_W'(r_cfg.long_thr);
            REG_WINDOW:   prdata = PDATA_W'(r_cfg.win_thr);
            REG_ACTIVE:   prdata = PDATA_W'(r_cfg.active_level);
        endcase
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign tick_acc = in_acc && (i_in.cmd == CMD_TICK);
    assign rd_acc   = in_acc && (i_in.cmd == CMD_READ);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        t_lane_ctl ctl;

        assign ctl.tick = tick_acc;
        // keys without a pin bit see level 0
        if (k < LEVEL_W) begin : g_pin
            assign ctl.pressed = (i_in.key_levels[k] == r_cfg.active_level);
        end else begin : g_nopin
            assign ctl.pressed = (r_cfg.active_level == 1'b0);
        end
        if (k < KEY_SPAN) begin : g_sel
            assign ctl.clear = rd_acc && (i_in.key_id == KEY_ID_W'(k));
        end else begin : g_nosel
            assign ctl.clear = 1'b0;
        end

        kcc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_ctl   (ctl),
            .o_pend  (pend[k])
        );
    end

    kcc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (rd_acc),
        .i_key_id (i_in.key_id),
        .i_pend   (pend),
        .o_ready  (i_in.ready),
        .o_out    (o_out)
    );

    `KCC_ASSERT(a_active_write,
        (cfg_wr && reg_sel == REG_ACTIVE) |=> (r_cfg.active_level == $past(pwdata[0])))

endmodule
